// ===== hdl/lbld_pkg.sv =====
// Shared types and constants of the line break and leakage detector.
package lbld_pkg;

  // Threshold registers are twelve bits wide, in raw ADC codes.
  localparam int unsigned CodeW = 12;

  // APB port geometry: two 32-bit registers at byte addresses 0 and 4.
  localparam int unsigned PaddrW = 3;
  localparam int unsigned PdataW = 32;

  // Register indexes as carried by paddr[2].
  localparam logic RegBreakThr  = 1'b0;
  localparam logic RegDetectThr = 1'b1;

  // Reset thresholds: 2.0 V and 1.2 V on a 3.3 V full scale of 4095 codes.
  localparam logic [CodeW-1:0] BreakThrReset  = 12'd2481;
  localparam logic [CodeW-1:0] DetectThrReset = 12'd1490;

  typedef enum logic [1:0] {
    CLS_NORMAL = 2'd0,
    CLS_OPEN   = 2'd1,
    CLS_DETECT = 2'd2
  } class_e;

  // Outcome of pairing one completed window with its predecessor.
  typedef struct packed {
    logic decided;
    logic wire_break;
    logic leakage;
  } decision_t;

endpackage

// ===== hdl/line_break_leakage_detector_top.sv =====
// Top level of the line break and leakage detector with its APB register port.
// Flow: a sample transaction is held in the input register, and the result of a
// completed window is loaded from there into the output register; a window-finishing
// sample waits while that register is still occupied. Throughput: one sample per cycle
// when no such wait holds it, set by the single compare-and-update pass between the registers.
// Reset: rst_ni is asynchronous and active low; it empties both registers, clears
// the window count, the pairing state and the flags, and loads the reset thresholds.
module line_break_leakage_detector_top #(
  parameter int unsigned WINDOW_LEN  = 5,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // Configuration port
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [lbld_pkg::PaddrW-1:0]             paddr,
  input  logic [lbld_pkg::PdataW-1:0]             pwdata,
  output logic [lbld_pkg::PdataW-1:0]             prdata,
  output logic                                    pready,
  // Sample channel
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic [SAMPLE_BITS-1:0]                  sample_i,
  input  logic                                    read_ok_i,
  // Result channel
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic [SAMPLE_BITS-1:0]                  window_min_o,
  output logic [SAMPLE_BITS-1:0]                  window_max_o,
  output logic [1:0]                              window_class_o,
  output logic                                    decided_o,
  output logic                                    wire_break_o,
  output logic                                    leakage_o
);

  localparam int unsigned CntW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int unsigned CmpW = (SAMPLE_BITS > lbld_pkg::CodeW) ? SAMPLE_BITS
                                                                 : lbld_pkg::CodeW;
  localparam logic [CntW-1:0] LastIdx = CntW'(WINDOW_LEN - 1);

  // ---------------------------------------------------------------------------
  // Threshold registers. Writes land on the access phase; pready is tied high.
  // ---------------------------------------------------------------------------
  logic [lbld_pkg::CodeW-1:0] break_thr_q;
  logic [lbld_pkg::CodeW-1:0] detect_thr_q;
  logic                       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      break_thr_q  <= lbld_pkg::BreakThrReset;
      detect_thr_q <= lbld_pkg::DetectThrReset;
    end else if (cfg_write) begin
      unique case (paddr[2])
        lbld_pkg::RegBreakThr:  break_thr_q  <= pwdata[lbld_pkg::CodeW-1:0];
        lbld_pkg::RegDetectThr: detect_thr_q <= pwdata[lbld_pkg::CodeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      lbld_pkg::RegBreakThr:  prdata = lbld_pkg::PdataW'(break_thr_q);
      lbld_pkg::RegDetectThr: prdata = lbld_pkg::PdataW'(detect_thr_q);
      default:                prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input register. A transaction sits here while it is folded into the
  // window; it is held back only when it finishes a window and the
  // output register is still occupied.
  // ---------------------------------------------------------------------------
  logic                   s1_valid_q;
  logic [SAMPLE_BITS-1:0] s1_sample_q;
  logic                   s1_read_ok_q;
  logic                   s1_done;     // this sample completes a window
  logic                   s1_advance;  // the held sample is consumed this cycle
  logic                   out_free;

  assign out_free   = !out_valid_o || out_ready_i;
  assign s1_advance = s1_valid_q && (!s1_done || out_free);
  assign in_ready_o = !s1_valid_q || s1_advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_sample_q  <= sample_i;
      s1_read_ok_q <= read_ok_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Running extremes of the current window. The first sample of a window loads
  // both; failed reads leave everything untouched.
  // ---------------------------------------------------------------------------
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [SAMPLE_BITS-1:0] min_q, min_d;
  logic [SAMPLE_BITS-1:0] max_q, max_d;
  logic                   first;
  logic                   take;

  assign first = (cnt_q == '0);
  assign take  = s1_advance && s1_read_ok_q;

  always_comb begin
    min_d = (first || (s1_sample_q < min_q)) ? s1_sample_q : min_q;
    max_d = (first || (s1_sample_q > max_q)) ? s1_sample_q : max_q;
    cnt_d = (cnt_q == LastIdx) ? '0 : cnt_q + CntW'(1);
  end

  assign s1_done = s1_read_ok_q && (cnt_q == LastIdx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (take) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      min_q <= min_d;
      max_q <= max_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Classification of the window minimum. Open line wins over detect level.
  // ---------------------------------------------------------------------------
  lbld_pkg::class_e cls;
  logic [CmpW-1:0]  min_wide;

  assign min_wide = CmpW'(min_d);

  always_comb begin
    if (min_wide > CmpW'(break_thr_q)) begin
      cls = lbld_pkg::CLS_OPEN;
    end else if (min_wide < CmpW'(detect_thr_q)) begin
      cls = lbld_pkg::CLS_DETECT;
    end else begin
      cls = lbld_pkg::CLS_NORMAL;
    end
  end

  // ---------------------------------------------------------------------------
  // Pairing of consecutive windows; updated once per completed window.
  // ---------------------------------------------------------------------------
  logic                win_update;
  lbld_pkg::decision_t decision;

  assign win_update = take && s1_done;

  lbld_pair u_pair (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .update_i   (win_update),
    .cls_i      (cls),
    .decision_o (decision)
  );

  // ---------------------------------------------------------------------------
  // Output register: one result transaction per completed window.
  // ---------------------------------------------------------------------------
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (win_update) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (win_update) begin
      window_min_o   <= min_d;
      window_max_o   <= max_d;
      window_class_o <= cls;
      decided_o      <= decision.decided;
      wire_break_o   <= decision.wire_break;
      leakage_o      <= decision.leakage;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/lbld_pair.sv =====
// Pairing of consecutive window classes and the wire break and leakage flags.
module lbld_pair (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    update_i,
  input  lbld_pkg::class_e        cls_i,
  output lbld_pkg::decision_t     decision_o
);

  lbld_pkg::class_e prev_cls_q, prev_cls_d;
  logic             have_prev_q, have_prev_d;
  logic             wire_break_q, wire_break_d;
  logic             leakage_q, leakage_d;

  always_comb begin
    prev_cls_d   = cls_i;
    have_prev_d  = 1'b1;
    wire_break_d = wire_break_q;
    leakage_d    = leakage_q;
    if (have_prev_q) begin
      wire_break_d = (prev_cls_q == lbld_pkg::CLS_OPEN) && (cls_i == lbld_pkg::CLS_OPEN);
      leakage_d    = (prev_cls_q == lbld_pkg::CLS_DETECT) && (cls_i == lbld_pkg::CLS_DETECT);
      // A normal window cannot open a pair, so two fresh windows are needed.
      have_prev_d  = (cls_i != lbld_pkg::CLS_NORMAL);
    end
  end

  assign decision_o.decided    = have_prev_q;
  assign decision_o.wire_break = wire_break_d;
  assign decision_o.leakage    = leakage_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_cls_q   <= lbld_pkg::CLS_NORMAL;
      have_prev_q  <= 1'b0;
      wire_break_q <= 1'b0;
      leakage_q    <= 1'b0;
    end else if (update_i) begin
      prev_cls_q   <= prev_cls_d;
      have_prev_q  <= have_prev_d;
      wire_break_q <= wire_break_d;
      leakage_q    <= leakage_d;
    end
  end

endmodule

// ===== hdl/lbld_checker.sv =====
// Port-level checks of the line break and leakage detector, bound to the top level.
module lbld_checker #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [SAMPLE_BITS-1:0] window_min_o,
  input logic [SAMPLE_BITS-1:0] window_max_o,
  input logic [1:0]             window_class_o,
  input logic                   decided_o,
  input logic                   wire_break_o,
  input logic                   leakage_o
);

  // A stalled result transaction keeps its valid, extremes, class and decided bit.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(window_min_o)
      && $stable(window_max_o) && $stable(window_class_o) && $stable(decided_o))
    else $error("result changed while stalled");

  a_min_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> window_min_o <= window_max_o)
    else $error("window minimum above window maximum");

  // A set flag needs a decided pair whose latest window has the matching class; a wire break also excludes leakage.
  a_break: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && wire_break_o |-> decided_o && !leakage_o
      && window_class_o == lbld_pkg::CLS_OPEN)
    else $error("wire break without an open-line pair");

  a_leak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && leakage_o |-> decided_o && window_class_o == lbld_pkg::CLS_DETECT)
    else $error("leakage without a detect pair");

  a_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid straight out of reset");

endmodule

bind line_break_leakage_detector_top lbld_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_lbld_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .window_min_o   (window_min_o),
  .window_max_o   (window_max_o),
  .window_class_o (window_class_o),
  .decided_o      (decided_o),
  .wire_break_o   (wire_break_o),
  .leakage_o      (leakage_o)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the line break and leakage detector top level.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned SampleW   = 12;
  localparam int unsigned WindowLen = 5;
  // A finished window only passes the input and the output register, so
  // SettleCycles spare cycles are enough for the block to settle.
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned FinalCycles  = 16;
  // The limit lies far above the longest quiet gap of a correct block.
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned MaxPrinted   = 100;

  typedef struct {
    logic [SampleW-1:0] lo;
    logic [SampleW-1:0] hi;
    lbld_pkg::class_e   cls;
    logic               decided;
    logic               wire_break;
    logic               leakage;
  } window_result_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [lbld_pkg::PaddrW-1:0]   paddr;
  logic [lbld_pkg::PdataW-1:0]   pwdata;
  logic [lbld_pkg::PdataW-1:0]   prdata;
  logic                          pready;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic [SampleW-1:0]            sample_i;
  logic                          read_ok_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic [SampleW-1:0]            window_min_o;
  logic [SampleW-1:0]            window_max_o;
  logic [1:0]                    window_class_o;
  logic                          decided_o;
  logic                          wire_break_o;
  logic                          leakage_o;

  // Predicted detector state, kept in step with every accepted transaction.
  logic [lbld_pkg::CodeW-1:0]    break_thr;
  logic [lbld_pkg::CodeW-1:0]    detect_thr;
  int unsigned                   fill;
  logic [SampleW-1:0]            low_q;
  logic [SampleW-1:0]            high_q;
  lbld_pkg::class_e              prev_cls;
  bit                            first_held;
  bit                            wire_break_q;
  bit                            leakage_q;

  window_result_t      pending_windows[$];
  window_result_t      got_window;
  int unsigned         mismatches;
  int unsigned         max_gap;
  int unsigned         max_stall;
  int unsigned         stall_left;
  int unsigned         quiet_cycles;

  line_break_leakage_detector_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_i       (sample_i),
    .read_ok_i      (read_ok_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .window_min_o   (window_min_o),
    .window_max_o   (window_max_o),
    .window_class_o (window_class_o),
    .decided_o      (decided_o),
    .wire_break_o   (wire_break_o),
    .leakage_o      (leakage_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Prints one line per mismatch, up to a cap so that a badly broken block cannot
  // flood the log, and counts every one of them.
  task automatic report_mismatch(input string msg);
    if (mismatches < MaxPrinted) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  // Folds one accepted sample into the predicted window and, when the window is
  // complete, queues the result that the block must return for it.
  task automatic track_window(input logic [SampleW-1:0] s, input logic ok);
    window_result_t   r;
    lbld_pkg::class_e cls;
    // A failed read leaves the detector untouched.
    if (!ok) return;
    // The first sample of a window loads both extremes.
    if (fill == 0) begin
      low_q  = s;
      high_q = s;
    end else begin
      if (s < low_q) low_q = s;
      if (s > high_q) high_q = s;
    end
    fill++;
    if (fill < WindowLen) return;
    fill = 0;
    // The open line test takes priority over the detect test.
    if (low_q > break_thr) cls = lbld_pkg::CLS_OPEN;
    else if (low_q < detect_thr) cls = lbld_pkg::CLS_DETECT;
    else cls = lbld_pkg::CLS_NORMAL;
    r.decided = first_held;
    if (first_held) begin
      wire_break_q = (prev_cls == lbld_pkg::CLS_OPEN) && (cls == lbld_pkg::CLS_OPEN);
      leakage_q    = (prev_cls == lbld_pkg::CLS_DETECT) && (cls == lbld_pkg::CLS_DETECT);
      // A non-normal window opens the next pair; a normal one needs two fresh ones.
      first_held   = (cls != lbld_pkg::CLS_NORMAL);
    end else begin
      first_held = 1'b1;
    end
    prev_cls     = cls;
    r.lo         = low_q;
    r.hi         = high_q;
    r.cls        = cls;
    r.wire_break = wire_break_q;
    r.leakage    = leakage_q;
    pending_windows.push_back(r);
  endtask

  // Sends one sample transaction after a random idle gap. Valid is left high on
  // return so that a back-to-back item keeps it high without a glitch.
  task automatic send_sample(input logic [SampleW-1:0] value, input logic ok);
    int unsigned gap;
    gap = $urandom_range(0, max_gap);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= value;
    read_ok_i  <= ok;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    track_window(value, ok);
  endtask

  // Drops valid, waits until every queued window has come back and lets the
  // pipeline run dry, so that the block is idle afterwards.
  task automatic wait_idle(input int unsigned extra);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_windows.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic reg_idx, input logic [lbld_pkg::CodeW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    // The upper data bits are noise that the register must drop.
    pwdata  <= {(lbld_pkg::PdataW - lbld_pkg::CodeW)'(
                  $urandom_range(0, (1 << (lbld_pkg::PdataW - lbld_pkg::CodeW)) - 1)),
                value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_check(input logic reg_idx, input logic [lbld_pkg::CodeW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {reg_idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[lbld_pkg::CodeW-1:0] !== value) begin
      report_mismatch($sformatf("register %0d reads %0d, expected %0d",
                                reg_idx, prdata[lbld_pkg::CodeW-1:0], value));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_thresholds(input logic [lbld_pkg::CodeW-1:0] brk,
                                input logic [lbld_pkg::CodeW-1:0] det);
    apb_write(lbld_pkg::RegBreakThr, brk);
    apb_write(lbld_pkg::RegDetectThr, det);
    break_thr  = brk;
    detect_thr = det;
    apb_check(lbld_pkg::RegBreakThr, brk);
    apb_check(lbld_pkg::RegDetectThr, det);
  endtask

  // Picks a window minimum that lands in the wanted class under the current
  // thresholds, often right on a boundary; returns -1 where the class is empty.
  function automatic int low_for_class(input lbld_pkg::class_e want);
    bit edge_pick;
    edge_pick = ($urandom_range(0, 3) == 0);
    case (want)
      lbld_pkg::CLS_OPEN: begin
        if (break_thr == {lbld_pkg::CodeW{1'b1}}) return -1;
        return edge_pick ? int'(break_thr) + 1 : int'($urandom_range(break_thr + 1, 4095));
      end
      lbld_pkg::CLS_DETECT: begin
        if (detect_thr == 0) return -1;
        return edge_pick ? int'(detect_thr) - 1 : int'($urandom_range(0, detect_thr - 1));
      end
      default: begin
        if (detect_thr > break_thr) return -1;
        if (edge_pick) return $urandom_range(0, 1) ? int'(break_thr) : int'(detect_thr);
        return int'($urandom_range(detect_thr, break_thr));
      end
    endcase
  endfunction

  // One whole window whose minimum is lo, with failed reads sprinkled in.
  task automatic send_window(input int lo);
    int unsigned        spot;
    int unsigned        k;
    logic [SampleW-1:0] s;
    spot = $urandom_range(0, WindowLen - 1);
    for (k = 0; k < WindowLen; k++) begin
      if ($urandom_range(0, 9) == 0) send_sample(SampleW'($urandom_range(0, 4095)), 1'b0);
      s = (k == spot) ? SampleW'(lo) : SampleW'($urandom_range(lo, 4095));
      send_sample(s, 1'b1);
    end
  endtask

  // Random windows: mostly runs of one class so that pairs form and flags get set,
  // with some windows of entirely random content mixed in.
  task automatic run_windows(input int unsigned count);
    lbld_pkg::class_e want;
    int               lo;
    int unsigned      w;
    want = lbld_pkg::CLS_NORMAL;
    for (w = 0; w < count; w++) begin
      if ($urandom_range(0, 99) < 15) begin
        lo = $urandom_range(0, 4095);
      end else begin
        if ($urandom_range(0, 99) >= 60) want = lbld_pkg::class_e'($urandom_range(0, 2));
        lo = low_for_class(want);
        if (lo < 0) lo = $urandom_range(0, 4095);
      end
      send_window(lo);
    end
    wait_idle(SettleCycles);
  endtask

  task automatic test_reset_values();
    apb_check(lbld_pkg::RegBreakThr, lbld_pkg::BreakThrReset);
    apb_check(lbld_pkg::RegDetectThr, lbld_pkg::DetectThrReset);
  endtask

  // Hand-built windows under the reset thresholds: full-scale codes, codes on
  // either side of each threshold, failed reads, an open pair, a mixed pair, a
  // detect pair and a normal window that clears the flags.
  task automatic test_directed_windows();
    // First window after reset: the first sample must load the minimum.
    send_sample(12'd4095, 1'b1);
    send_sample(12'd0,    1'b0);
    send_sample(12'd4095, 1'b1);
    send_sample(12'd4095, 1'b1);
    send_sample(12'd4095, 1'b0);
    send_sample(12'd4095, 1'b1);
    send_sample(12'd4095, 1'b1);
    // Minimum one above the break threshold: second open window, wire break.
    send_sample(12'd2482, 1'b1);
    send_sample(12'd4095, 1'b1);
    send_sample(12'd3000, 1'b1);
    send_sample(12'd2600, 1'b1);
    send_sample(12'd4000, 1'b1);
    // A fresh window must not inherit the old minimum; detect after open clears.
    send_sample(12'd3000, 1'b1);
    send_sample(12'd1489, 1'b1);
    send_sample(12'd2000, 1'b1);
    send_sample(12'd1200, 1'b1);
    send_sample(12'd1489, 1'b1);
    // One below the detect threshold throughout: second detect window, leakage.
    repeat (WindowLen) send_sample(12'd1489, 1'b1);
    // Minimum exactly on the detect threshold, maximum at full scale: normal.
    send_sample(12'd2481, 1'b1);
    send_sample(12'd1490, 1'b1);
    send_sample(12'd4095, 1'b1);
    send_sample(12'd2000, 1'b1);
    send_sample(12'd1490, 1'b1);
    wait_idle(SettleCycles);
  endtask

  // Both sides run without idling, so sample transactions go through every cycle.
  task automatic test_back_to_back();
    max_gap   = 0;
    max_stall = 0;
    run_windows(30);
    max_gap   = 15;
    max_stall = 15;
  endtask

  // Corner settings: nothing open or detect, almost everything open, almost
  // everything detect, empty normal band, and a return to the reset values.
  task automatic test_threshold_extremes();
    set_thresholds(12'd4095, 12'd0);
    run_windows(25);
    set_thresholds(12'd0, 12'd4095);
    run_windows(25);
    max_stall = 0;
    set_thresholds(12'd0, 12'd0);
    run_windows(25);
    max_stall = 15;
    max_gap   = 0;
    set_thresholds(12'd4095, 12'd4095);
    run_windows(25);
    max_gap   = 15;
    set_thresholds(lbld_pkg::BreakThrReset, lbld_pkg::DetectThrReset);
    run_windows(25);
  endtask

  task automatic test_random_thresholds();
    int unsigned n;
    for (n = 0; n < 4; n++) begin
      set_thresholds((lbld_pkg::CodeW)'($urandom_range(0, 4095)),
                     (lbld_pkg::CodeW)'($urandom_range(0, 4095)));
      run_windows(25);
    end
  endtask

  // Result side: checks each result transaction against the oldest queued
  // window and draws a fresh stall after every one.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_windows.size() == 0) begin
          report_mismatch("result transaction with no window pending");
        end else begin
          got_window = pending_windows.pop_front();
          if (window_min_o !== got_window.lo)
            report_mismatch($sformatf("window_min %0d, expected %0d",
                                      window_min_o, got_window.lo));
          if (window_max_o !== got_window.hi)
            report_mismatch($sformatf("window_max %0d, expected %0d",
                                      window_max_o, got_window.hi));
          if (window_class_o !== got_window.cls)
            report_mismatch($sformatf("window_class %0d, expected %s",
                                      window_class_o, got_window.cls.name()));
          if (decided_o !== got_window.decided)
            report_mismatch($sformatf("decided %b, expected %b",
                                      decided_o, got_window.decided));
          if (wire_break_o !== got_window.wire_break)
            report_mismatch($sformatf("wire_break %b, expected %b",
                                      wire_break_o, got_window.wire_break));
          if (leakage_o !== got_window.leakage)
            report_mismatch($sformatf("leakage %b, expected %b",
                                      leakage_o, got_window.leakage));
        end
        stall_left = $urandom_range(0, max_stall);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_ready_i <= (stall_left == 0);
    end
  end

  // Watchdog: any transaction on either channel or the register port restarts
  // the count of quiet cycles.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (psel && penable && pready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("line_break_leakage_detector_top test failed");
        $finish;
      end
    end
  end

  initial begin
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid_i   = 1'b0;
    sample_i     = '0;
    read_ok_i    = 1'b0;
    out_ready_i  = 1'b0;
    mismatches   = 0;
    max_gap      = 15;
    max_stall    = 15;
    stall_left   = 0;
    quiet_cycles = 0;
    break_thr    = lbld_pkg::BreakThrReset;
    detect_thr   = lbld_pkg::DetectThrReset;
    fill         = 0;
    low_q        = '0;
    high_q       = '0;
    prev_cls     = lbld_pkg::CLS_NORMAL;
    first_held   = 1'b0;
    wire_break_q = 1'b0;
    leakage_q    = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_directed_windows();
    test_back_to_back();
    test_threshold_extremes();
    test_random_thresholds();

    wait_idle(FinalCycles);
    if (pending_windows.size() != 0) begin
      report_mismatch($sformatf("%0d windows never returned", pending_windows.size()));
    end
    if (mismatches == 0) begin
      $display("line_break_leakage_detector_top test passed");
    end else begin
      $display("line_break_leakage_detector_top test failed");
    end
    $finish;
  end

endmodule
